/* hdl/view_frustum_cull_test_macros.svh */
// Assertion macros for the frustum cull block
`ifndef VIEW_FRUSTUM_CULL_TEST_MACROS_SVH
`define VIEW_FRUSTUM_CULL_TEST_MACROS_SVH

// same-cycle implication, disabled during reset
`define VFC_ASSERT_SAME(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("vfc assertion failed");

// next-cycle implication, disabled during reset
`define VFC_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("vfc assertion failed");

`endif

/* hdl/vfc_pkg.sv */
// Types and constants shared by the frustum cull block
`timescale 1ns / 1ps

package vfc_pkg;

    localparam int PlaneCount = 6;
    localparam int CoordW     = 16;
    localparam int RadiusW    = 15;
    localparam int FracShift  = 14;
    // three Q1.14 x Q11.4 products plus the scaled offset fit in 34 bits
    localparam int DistW      = 34;
    localparam int AddrW      = 6;
    localparam int IdxW       = 3;
    localparam int DataW      = 64;

    typedef enum logic [1:0] {
        CMD_POINT  = 2'd0,
        CMD_SPHERE = 2'd1,
        CMD_BOX    = 2'd2
    } cmd_t;

    typedef enum logic [IdxW-1:0] {
        REG_TOP    = 3'd0,
        REG_BOTTOM = 3'd1,
        REG_LEFT   = 3'd2,
        REG_RIGHT  = 3'd3,
        REG_NEAR   = 3'd4,
        REG_FAR    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [CoordW-1:0] d;
        logic signed [CoordW-1:0] nz;
        logic signed [CoordW-1:0] ny;
        logic signed [CoordW-1:0] nx;
    } plane_t;

    typedef struct packed {
        logic                     is_box;
        logic signed [DistW-1:0]  limit;
    } test_ctl_t;

endpackage

/* hdl/vfc_item_if.sv */
// Input item channel: one bounding volume test per transaction
`timescale 1ns / 1ps

interface vfc_item_if import vfc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                command;
    logic signed [CoordW-1:0]  pos_x;
    logic signed [CoordW-1:0]  pos_y;
    logic signed [CoordW-1:0]  pos_z;
    logic signed [CoordW-1:0]  max_x;
    logic signed [CoordW-1:0]  max_y;
    logic signed [CoordW-1:0]  max_z;
    logic [RadiusW-1:0]        radius;

    modport source (
        output valid, command, pos_x, pos_y, pos_z, max_x, max_y, max_z, radius,
        input  ready
    );
    modport sink (
        input  valid, command, pos_x, pos_y, pos_z, max_x, max_y, max_z, radius,
        output ready
    );
endinterface

/* hdl/vfc_result_if.sv */
// Result channel: one visibility bit per transaction
`timescale 1ns / 1ps

interface vfc_result_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink (input valid, visible, output ready);
endinterface

/* hdl/vfc_cfg_regs.sv */
// APB register file holding the six frustum planes
`timescale 1ns / 1ps

module vfc_cfg_regs import vfc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [AddrW-1:0]  paddr,
    input  logic [DataW-1:0]  pwdata,
    output logic [DataW-1:0]  prdata,
    output logic              pready,
    output plane_t            planes [PlaneCount]
);

    plane_t           plane_reg [PlaneCount];
    logic [IdxW-1:0]  idx;
    logic             wr_en;

    assign idx    = paddr[AddrW-1:AddrW-IdxW];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PlaneCount; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (wr_en && (32'(idx) < PlaneCount))
        begin
            plane_reg[idx] <= plane_t'(pwdata);
        end
    end

    always_comb
    begin
        if (32'(idx) < PlaneCount)
        begin
            prdata = DataW'(plane_reg[idx]);
        end
        else
        begin
            prdata = '0;
        end
    end

    assign planes = plane_reg;

endmodule

/* hdl/vfc_plane_test.sv */
// Signed distance of one vertex to one plane and the reject decision
`timescale 1ns / 1ps

module vfc_plane_test import vfc_pkg::*; (
    input  plane_t                    plane,
    input  test_ctl_t                 ctl,
    input  logic signed [CoordW-1:0]  pos_x,
    input  logic signed [CoordW-1:0]  pos_y,
    input  logic signed [CoordW-1:0]  pos_z,
    input  logic signed [CoordW-1:0]  max_x,
    input  logic signed [CoordW-1:0]  max_y,
    input  logic signed [CoordW-1:0]  max_z,
    output logic                      reject
);

    logic signed [CoordW-1:0]    vx, vy, vz;
    logic signed [2*CoordW-1:0]  px, py, pz;
    logic signed [DistW-1:0]     d_scaled;
    logic signed [DistW-1:0]     distance;

    // positive vertex: max corner only where the normal is strictly positive
    assign vx = (ctl.is_box && plane.nx > 0) ? max_x : pos_x;
    assign vy = (ctl.is_box && plane.ny > 0) ? max_y : pos_y;
    assign vz = (ctl.is_box && plane.nz > 0) ? max_z : pos_z;

    assign px = plane.nx * vx;
    assign py = plane.ny * vy;
    assign pz = plane.nz * vz;

    assign d_scaled = {{(DistW-CoordW-FracShift){plane.d[CoordW-1]}}, plane.d,
                       {FracShift{1'b0}}};

    assign distance = DistW'(px) + DistW'(py) + DistW'(pz) + d_scaled;

    assign reject = distance < ctl.limit;

endmodule

/* hdl/view_frustum_cull_test.sv */
// Top level: six-plane view frustum cull test
//
// Channels: item (sink) carries one test per transaction: command selects
// point, sphere or axis-aligned box; pos_* is the point, sphere centre or
// box min corner, max_* the box max corner, radius the sphere radius.
// result (source) returns one visible bit per item, in order.
// Planes are written over the APB port, 8 bytes per plane at 8*index
// (top, bottom, left, right, near, far); write them only while idle.
// Pipeline: an item passes from the input register to the result register,
// which takes it as soon as it is empty or the receiver is ready.
// Throughput: one item per cycle while result.ready stays high;
// all six plane distances are formed in parallel between the two registers.
// Reset clears the planes to zero (every item visible) and empties both
// stages. When the receiver stalls, the result register holds and the input
// register still takes one more item; item.ready drops only when both are
// full and result.ready is low.
`timescale 1ns / 1ps

`include "view_frustum_cull_test_macros.svh"

module view_frustum_cull_test import vfc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    vfc_item_if.sink          item,
    vfc_result_if.source      result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [AddrW-1:0]  paddr,
    input  logic [DataW-1:0]  pwdata,
    output logic [DataW-1:0]  prdata,
    output logic              pready
);

    plane_t                    planes [PlaneCount];

    logic                      s1_valid_reg, s1_valid_next;
    logic [1:0]                cmd_reg;
    logic signed [CoordW-1:0]  pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [CoordW-1:0]  max_x_reg, max_y_reg, max_z_reg;
    logic [RadiusW-1:0]        radius_reg;

    logic                      out_valid_reg, out_valid_next;
    logic                      visible_reg;

    logic                      out_free;
    logic                      item_take;
    test_ctl_t                 ctl;
    logic [PlaneCount-1:0]     reject;

    vfc_cfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes)
    );

    assign out_free   = !out_valid_reg || result.ready;
    assign item.ready = !s1_valid_reg || out_free;
    assign item_take  = item.valid && item.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item.ready)
        begin
            s1_valid_next = item.valid;
        end
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            cmd_reg    <= item.command;
            pos_x_reg  <= item.pos_x;
            pos_y_reg  <= item.pos_y;
            pos_z_reg  <= item.pos_z;
            max_x_reg  <= item.max_x;
            max_y_reg  <= item.max_y;
            max_z_reg  <= item.max_z;
            radius_reg <= item.radius;
        end
    end

    // sphere passes down to -radius; the unused code behaves as a box
    always_comb
    begin
        ctl.is_box = 1'b1;
        ctl.limit  = '0;
        unique case (cmd_reg)
            CMD_POINT:
            begin
                ctl.is_box = 1'b0;
            end
            CMD_SPHERE:
            begin
                ctl.is_box = 1'b0;
                ctl.limit  = -DistW'({radius_reg, {FracShift{1'b0}}});
            end
            default:
            begin
                ctl.is_box = 1'b1;
            end
        endcase
    end

    for (genvar p = 0; p < PlaneCount; p++)
    begin : g_plane
        vfc_plane_test u_test (
            .plane  (planes[p]),
            .ctl    (ctl),
            .pos_x  (pos_x_reg),
            .pos_y  (pos_y_reg),
            .pos_z  (pos_z_reg),
            .max_x  (max_x_reg),
            .max_y  (max_y_reg),
            .max_z  (max_z_reg),
            .reject (reject[p])
        );
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            visible_reg <= ~|reject;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.visible = visible_reg;

    `VFC_ASSERT_SAME(a_stall_blocks_input, clk, rst_n,
        s1_valid_reg && out_valid_reg && !result.ready, !item.ready)
    `VFC_ASSERT_NEXT(a_take_fills_stage, clk, rst_n, item_take, s1_valid_reg)
    `VFC_ASSERT_NEXT(a_stage_moves_out, clk, rst_n, s1_valid_reg && out_free,
        out_valid_reg)
    `VFC_ASSERT_NEXT(a_far_plane_write, clk, rst_n,
        psel && penable && pwrite && paddr[AddrW-1:AddrW-IdxW] == REG_FAR,
        planes[REG_FAR] == plane_t'($past(pwdata)))

endmodule
